/* hw/rtl/bpfm_pkg.sv */
// Package for the buffer pool frame manager: command and status codes,
// sequencer states and the command/status structs between controller and datapath.
// No dependencies.
package bpfm_pkg;

  localparam int FRAMES_DEF   = 16;
  localparam int PIN_BITS_DEF = 8;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 48;

  typedef enum logic [2:0] {
    CMD_FETCH     = 3'd0,
    CMD_UNPIN     = 3'd1,
    CMD_NEW_PAGE  = 3'd2,
    CMD_FLUSH     = 3'd3,
    CMD_FLUSH_ALL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_NO_FRAME     = 3'd1,
    STS_NOT_ON_DISK  = 3'd2,
    STS_NOT_RESIDENT = 3'd3,
    STS_PIN_ZERO     = 3'd4,
    STS_PIN_SAT      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_TAKE,
    ST_VIC,
    ST_FA_START,
    ST_FA_CHK,
    ST_FA_EMIT
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_LOOK,
    ACT_ERR,
    ACT_PIN,
    ACT_UNPIN,
    ACT_FLUSH,
    ACT_ALLOC_NEW,
    ACT_ALLOC_VIC,
    ACT_FA_NONE,
    ACT_FA_SKIP,
    ACT_FA_EMIT
  } act_t;

  typedef struct packed {
    act_t    act;
    status_t st;
    logic    hit;
    logic    frm;
    logic    rd_vic;
  } ctl_t;

  typedef struct packed {
    cmd_t in_cmd;
    cmd_t cmd;
    logic look_done;
    logic found;
    logic pins_max;
    logic pins_zero;
    logic off_disk;
    logic unused_avail;
    logic lru_empty;
    logic any_dirty;
    logic cur_dirty;
    logic fa_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/bpfm_ctrl.sv */
// Sequencer of the buffer pool frame manager: steps each command through
// lookup, decision, allocation and flush phases. Depends on bpfm_pkg.
module bpfm_ctrl import bpfm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (sts.in_cmd)
            CMD_FETCH, CMD_UNPIN, CMD_FLUSH: state_nxt = ST_LOOK;
            CMD_NEW_PAGE:                    state_nxt = ST_TAKE;
            CMD_FLUSH_ALL:                   state_nxt = ST_FA_START;
            default:                         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        if (sts.look_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          if (sts.cmd == CMD_FETCH && !sts.found && !sts.off_disk) state_nxt = ST_TAKE;
          else state_nxt = ST_IDLE;
        end
      end
      ST_TAKE: begin
        if (sts.out_free) begin
          if (sts.unused_avail || sts.lru_empty) state_nxt = ST_IDLE;
          else state_nxt = ST_VIC;
        end
      end
      ST_VIC: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_FA_START: begin
        if (sts.any_dirty) state_nxt = ST_FA_CHK;
        else if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_FA_CHK: begin
        if (sts.cur_dirty) state_nxt = ST_FA_EMIT;
      end
      ST_FA_EMIT: begin
        if (sts.out_free) state_nxt = sts.fa_last ? ST_IDLE : ST_FA_CHK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '{act: ACT_NONE, st: STS_OK, hit: 1'b0, frm: 1'b0, rd_vic: 1'b0};
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.act = ACT_LOAD;
      end
      ST_LOOK: ctl.act = ACT_LOOK;
      ST_DECIDE: begin
        if (sts.out_free) begin
          case (sts.cmd)
            CMD_FETCH: begin
              if (sts.found) begin
                if (sts.pins_max) begin
                  ctl.act = ACT_ERR;
                  ctl.st  = STS_PIN_SAT;
                  ctl.hit = 1'b1;
                  ctl.frm = 1'b1;
                end else begin
                  ctl.act = ACT_PIN;
                end
              end else if (sts.off_disk) begin
                ctl.act = ACT_ERR;
                ctl.st  = STS_NOT_ON_DISK;
              end
            end
            CMD_UNPIN: begin
              if (!sts.found) begin
                ctl.act = ACT_ERR;
                ctl.st  = STS_NOT_RESIDENT;
              end else if (sts.pins_zero) begin
                ctl.act = ACT_ERR;
                ctl.st  = STS_PIN_ZERO;
                ctl.frm = 1'b1;
              end else begin
                ctl.act = ACT_UNPIN;
              end
            end
            CMD_FLUSH: begin
              if (!sts.found) begin
                ctl.act = ACT_ERR;
                ctl.st  = STS_NOT_RESIDENT;
              end else begin
                ctl.act = ACT_FLUSH;
              end
            end
            default: ctl.act = ACT_NONE;
          endcase
        end
      end
      ST_TAKE: begin
        ctl.rd_vic = 1'b1;
        if (sts.out_free) begin
          if (sts.unused_avail) begin
            ctl.act = ACT_ALLOC_NEW;
          end else if (sts.lru_empty) begin
            ctl.act = ACT_ERR;
            ctl.st  = STS_NO_FRAME;
          end
        end
      end
      ST_VIC: begin
        ctl.rd_vic = 1'b1;
        if (sts.out_free) ctl.act = ACT_ALLOC_VIC;
      end
      ST_FA_START: begin
        if (!sts.any_dirty && sts.out_free) ctl.act = ACT_FA_NONE;
      end
      ST_FA_CHK: begin
        if (!sts.cur_dirty) ctl.act = ACT_FA_SKIP;
      end
      ST_FA_EMIT: begin
        if (sts.out_free) ctl.act = ACT_FA_EMIT;
      end
      default: ctl.act = ACT_NONE;
    endcase
  end

endmodule

/* hw/rtl/bpfm_dp.sv */
// Datapath of the buffer pool frame manager: frame metadata, page id memory,
// LRU ranks, scan counter and result register. Depends on bpfm_pkg.
module bpfm_dp import bpfm_pkg::*; #(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [2:0]             in_tuser,
  input  ctl_t                   ctl,
  output sts_t                   sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  // Latched command
  cmd_t        cmd_r;
  logic [31:0] pid_r;
  logic        dflag_r;
  logic [31:0] disk_r;

  // Frame metadata
  logic [31:0]         page_mem [FRAMES];
  logic [31:0]         rdata_r;
  logic [FRAMES-1:0]   res_r;
  logic [FRAMES-1:0]   dirty_r;
  logic [PIN_BITS-1:0] pins_r [FRAMES];
  logic [FRAMES-1:0]   in_lru_r;
  logic [CW-1:0]       rank_r [FRAMES];
  logic [CW-1:0]       lru_cnt_r;
  logic [CW-1:0]       unused_r;

  // Scan and lookup
  logic [FW-1:0] scan_r;
  logic [FW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          found_r;
  logic [FW-1:0] fidx_r;

  // Result register
  logic        o_vld_r;
  logic [2:0]  o_st_r;
  logic        o_hit_r, o_load_r, o_zero_r, o_wbv_r, o_last_r;
  logic [3:0]  o_frm_r, o_wbf_r;
  logic [31:0] o_wbpid_r;

  logic [FW-1:0] vic;
  logic [FW-1:0] rd_addr;
  logic          hit_now, end_now, out_free;
  logic          more_dirty;
  logic [FRAMES-1:0] dmask;

  logic          emit;
  logic [2:0]    e_st;
  logic          e_hit, e_load, e_zero, e_wbv, e_last;
  logic [FW-1:0] e_frm, e_wbf;
  logic [31:0]   e_wbpid;
  logic          rm_en, ap_en, wr_en;
  logic [FW-1:0] rm_f, ap_f, wr_f;

  assign dmask    = res_r & dirty_r;
  assign out_free = !o_vld_r || out_tready;
  assign hit_now  = cmp_vld_r && res_r[cmp_idx_r] && (rdata_r == pid_r);
  assign end_now  = cmp_vld_r && (cmp_idx_r == FW'(FRAMES - 1));

  // The LRU head is the frame holding rank zero.
  always_comb begin
    vic = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (in_lru_r[j] && rank_r[j] == '0) vic = vic | FW'(j);
    end
  end

  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < FRAMES; j++) begin
      if (FW'(j) > scan_r && dmask[j]) more_dirty = 1'b1;
    end
  end

  assign rd_addr = ctl.rd_vic ? vic : scan_r;

  always_ff @(posedge clk) begin
    rdata_r <= page_mem[rd_addr];
    if (wr_en) page_mem[wr_f] <= pid_r;
  end

  always_comb begin
    sts.in_cmd       = cmd_t'(in_tuser);
    sts.cmd          = cmd_r;
    sts.look_done    = hit_now || end_now;
    sts.found        = found_r;
    sts.pins_max     = (pins_r[fidx_r] == '1);
    sts.pins_zero    = (pins_r[fidx_r] == '0);
    sts.off_disk     = (pid_r >= disk_r);
    sts.unused_avail = (unused_r < CW'(FRAMES));
    sts.lru_empty    = (lru_cnt_r == '0);
    sts.any_dirty    = |dmask;
    sts.cur_dirty    = dmask[scan_r];
    sts.fa_last      = !more_dirty;
    sts.out_free     = out_free;
  end

  always_comb begin
    emit = 1'b0;  e_st = STS_OK;  e_hit = 1'b0;  e_frm = '0;  e_load = 1'b0;
    e_zero = 1'b0;  e_wbv = 1'b0;  e_wbpid = '0;  e_wbf = '0;  e_last = 1'b1;
    rm_en = 1'b0;  rm_f = fidx_r;  ap_en = 1'b0;  ap_f = fidx_r;
    wr_en = 1'b0;  wr_f = vic;
    case (ctl.act)
      ACT_ERR: begin
        emit  = 1'b1;
        e_st  = ctl.st;
        e_hit = ctl.hit;
        e_frm = ctl.frm ? fidx_r : '0;
      end
      ACT_PIN: begin
        emit  = 1'b1;
        e_hit = 1'b1;
        e_frm = fidx_r;
        rm_en = (pins_r[fidx_r] == '0);
      end
      ACT_UNPIN: begin
        emit  = 1'b1;
        e_frm = fidx_r;
        ap_en = (pins_r[fidx_r] == PIN_BITS'(1));
      end
      ACT_FLUSH: begin
        emit    = 1'b1;
        e_frm   = fidx_r;
        e_wbv   = 1'b1;
        e_wbpid = pid_r;
        e_wbf   = fidx_r;
      end
      ACT_ALLOC_NEW: begin
        emit   = 1'b1;
        e_frm  = unused_r[FW-1:0];
        e_load = (cmd_r == CMD_FETCH);
        e_zero = (cmd_r == CMD_NEW_PAGE);
        wr_en  = 1'b1;
        wr_f   = unused_r[FW-1:0];
      end
      ACT_ALLOC_VIC: begin
        emit    = 1'b1;
        e_frm   = vic;
        e_load  = (cmd_r == CMD_FETCH);
        e_zero  = (cmd_r == CMD_NEW_PAGE);
        e_wbv   = dirty_r[vic];
        e_wbpid = dirty_r[vic] ? rdata_r : '0;
        e_wbf   = dirty_r[vic] ? vic : '0;
        rm_en   = 1'b1;
        rm_f    = vic;
        wr_en   = 1'b1;
        wr_f    = vic;
      end
      ACT_FA_NONE: emit = 1'b1;
      ACT_FA_EMIT: begin
        emit    = 1'b1;
        e_frm   = scan_r;
        e_wbv   = 1'b1;
        e_wbpid = rdata_r;
        e_wbf   = scan_r;
        e_last  = !more_dirty;
      end
      default: emit = 1'b0;
    endcase
  end

  // Command capture, lookup scan and flush-all scan
  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_LOAD: begin
        cmd_r     <= cmd_t'(in_tuser);
        pid_r     <= in_tdata[31:0];
        dflag_r   <= in_tdata[32];
        disk_r    <= in_tdata[64:33];
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end
      ACT_LOOK: begin
        if (hit_now || end_now) begin
          found_r <= hit_now;
          fidx_r  <= cmp_idx_r;
        end else begin
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= scan_r;
          scan_r    <= scan_r + 1'b1;
        end
      end
      ACT_FA_SKIP, ACT_FA_EMIT: scan_r <= scan_r + 1'b1;
      default: ;
    endcase
  end

  // Frame flags, pin counts and LRU ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r     <= '0;
      dirty_r   <= '0;
      in_lru_r  <= '0;
      lru_cnt_r <= '0;
      unused_r  <= '0;
      for (int j = 0; j < FRAMES; j++) pins_r[j] <= '0;
    end else begin
      case (ctl.act)
        ACT_PIN: pins_r[fidx_r] <= pins_r[fidx_r] + 1'b1;
        ACT_UNPIN: begin
          pins_r[fidx_r] <= pins_r[fidx_r] - 1'b1;
          if (dflag_r) dirty_r[fidx_r] <= 1'b1;
        end
        ACT_FLUSH:   dirty_r[fidx_r] <= 1'b0;
        ACT_FA_EMIT: dirty_r[scan_r] <= 1'b0;
        ACT_ALLOC_NEW, ACT_ALLOC_VIC: begin
          res_r[wr_f]   <= 1'b1;
          dirty_r[wr_f] <= 1'b0;
          pins_r[wr_f]  <= PIN_BITS'(1);
          if (ctl.act == ACT_ALLOC_NEW) unused_r <= unused_r + 1'b1;
        end
        default: ;
      endcase
      if (rm_en) begin
        for (int j = 0; j < FRAMES; j++) begin
          if (in_lru_r[j] && rank_r[j] > rank_r[rm_f]) rank_r[j] <= rank_r[j] - 1'b1;
        end
        in_lru_r[rm_f] <= 1'b0;
        lru_cnt_r      <= lru_cnt_r - 1'b1;
      end else if (ap_en) begin
        rank_r[ap_f]   <= lru_cnt_r;
        in_lru_r[ap_f] <= 1'b1;
        lru_cnt_r      <= lru_cnt_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (emit) begin
      o_vld_r <= 1'b1;
    end else if (out_tready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_st_r    <= e_st;
      o_hit_r   <= e_hit;
      o_frm_r   <= 4'(e_frm);
      o_load_r  <= e_load;
      o_zero_r  <= e_zero;
      o_wbv_r   <= e_wbv;
      o_wbpid_r <= e_wbpid;
      o_wbf_r   <= 4'(e_wbf);
      o_last_r  <= e_last;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {1'b0, o_wbf_r, o_wbpid_r, o_wbv_r, o_zero_r, o_load_r,
                       o_frm_r, o_hit_r, o_st_r};

endmodule

/* hw/rtl/buffer_pool_frame_manager_top.sv */
// Buffer pool frame manager, top level. One command at a time: fetch, unpin and flush
// scan the page ids one frame per cycle; a fetch miss then takes an unused frame or a
// victim, and flush all visits each frame up to the last dirty one, with one result per
// dirty frame or a single result if none is dirty. Output stalls hold the sequencer.
// Reset (synchronous, rst_n low) clears all flags, pin counts and the LRU; page ids need
// no clearing pass.
module buffer_pool_frame_manager_top import bpfm_pkg::*; #(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // page_id[31:0], dirty_flag[32], pages_on_disk[64:33], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[2:0], hit[3], frame[7:4], load_needed[8], zero_fill[9],
  // writeback_valid[10], writeback_page_id[42:11], writeback_frame[46:43]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  // The controller sequences each transaction; the datapath holds the frame state and results.
  ctl_t ctl;
  sts_t sts;

  bpfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bpfm_dp #(
    .FRAMES   (FRAMES),
    .PIN_BITS (PIN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // A write-back always names the frame that the result reports.
  a_wb_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[46:43] == out_tdata[7:4])
    else $error("write-back frame differs from result frame");

  // An error result never asks for a load or a write-back.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != STS_OK |-> !out_tdata[10] && !out_tdata[8])
    else $error("error result carries a load or write-back");

  // A valid command keeps the sequencer busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser <= CMD_FLUSH_ALL |=> !in_tready)
    else $error("sequencer idle straight after a command");
`endif

endmodule
